/* hdl/ctw_pkg.sv */
// Shared constants for the hue wheel color tween core.
// No dependencies; used by ctw_div and color_tween_via_hue_wheel_core.
`default_nettype none

package ctw_pkg;

   // Quotient bits resolved per divider pipeline stage.
   localparam int DIV_STEPS = 4;

   // Six zones of the hue wheel, in wheel order.
   localparam logic [2:0] HUE_RED     = 3'd0;
   localparam logic [2:0] HUE_YELLOW  = 3'd1;
   localparam logic [2:0] HUE_GREEN   = 3'd2;
   localparam logic [2:0] HUE_CYAN    = 3'd3;
   localparam logic [2:0] HUE_BLUE    = 3'd4;
   localparam logic [2:0] HUE_MAGENTA = 3'd5;

endpackage

`default_nettype wire

/* hdl/ctw_div.sv */
// Pipelined unsigned restoring divider, ctw_pkg::DIV_STEPS quotient bits per stage.
// Depends on ctw_pkg.
`default_nettype none

module ctw_div #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 8
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quo
);

   localparam int STAGES = (NUM_W + ctw_pkg::DIV_STEPS - 1) / ctw_pkg::DIV_STEPS;
   localparam int PAD_W  = STAGES * ctw_pkg::DIV_STEPS;

   logic [DEN_W-1:0] rem_ff [STAGES];
   logic [DEN_W-1:0] rem_in [STAGES];
   logic [DEN_W-1:0] den_ff [STAGES];
   logic [PAD_W-1:0] num_ff [STAGES];
   logic [PAD_W-1:0] num_in [STAGES];
   logic [PAD_W-1:0] quo_ff [STAGES];
   logic [PAD_W-1:0] quo_in [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic [DEN_W-1:0] rem_src;
      logic [DEN_W-1:0] den_src;
      logic [PAD_W-1:0] num_src;
      logic [PAD_W-1:0] quo_src;
      logic [DEN_W-1:0] rem_nx;
      logic [PAD_W-1:0] num_nx;
      logic [PAD_W-1:0] quo_nx;

      if (k == 0) begin : g_first
         assign rem_src = '0;
         assign num_src = PAD_W'(num);
         assign quo_src = '0;
         assign den_src = den;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign num_src = num_ff[k-1];
         assign quo_src = quo_ff[k-1];
         assign den_src = den_ff[k-1];
      end

      always_comb begin
         logic [DEN_W:0]   trial;
         logic [DEN_W:0]   diff;
         logic [DEN_W-1:0] r;
         logic [PAD_W-1:0] n;
         logic [PAD_W-1:0] q;
         r = rem_src;
         n = num_src;
         q = quo_src;
         for (int j = 0; j < ctw_pkg::DIV_STEPS; j++) begin
            trial = {r, n[PAD_W-1]};
            n     = n << 1;
            diff  = trial - {1'b0, den_src};
            if (trial >= {1'b0, den_src}) begin
               q = {q[PAD_W-2:0], 1'b1};
               r = diff[DEN_W-1:0];
            end else begin
               q = {q[PAD_W-2:0], 1'b0};
               r = trial[DEN_W-1:0];
            end
         end
         rem_nx = r;
         num_nx = n;
         quo_nx = q;
      end

      assign rem_in[k] = rem_nx;
      assign num_in[k] = num_nx;
      assign quo_in[k] = quo_nx;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in[k];
            num_ff[k] <= num_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= den_src;
         end
      end
   end

   assign quo = quo_ff[STAGES-1][NUM_W-1:0];

endmodule

`default_nettype wire

/* hdl/color_tween_via_hue_wheel_core.sv */
// Top level of the hue wheel color tween: RGB -> HSV, blend, HSV -> RGB.
// Depends on ctw_pkg and ctw_div.
`default_nettype none

// Usage
//  - req_ channel: two RGB colors, a tween fraction (FRACTION_BITS+1 bits, values
//    above 1.0 clamp to 1.0) and a hue direction (0 forward, 1 backward).
//  - rsp_ channel: the blended RGB color, one item out for each item in.
//  - Both channels are valid/ready; an item moves when valid and ready are high.
//  - Throughput: one item per cycle. The whole pipe advances together whenever
//    the output register is empty or being taken, so req_ready is high unless
//    a result is held by a stalled receiver.
//  - The divider pipeline for the min/max and middle ratios is the bulk of
//    the pipe; it resolves four quotient bits per stage. Lightness is a bit
//    replication and hue/6 a one-stage reciprocal multiply.
//  - Receiver stall: all stages freeze, nothing is dropped or repeated; the
//    held result stays on rsp_ until taken.
//  - Reset (synchronous, active high) clears every valid bit; the data
//    registers are don't-care until refilled. No clearing pass is needed.
module color_tween_via_hue_wheel_core #(
   parameter int COLOR_BITS    = 8,
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [COLOR_BITS-1:0]    req_red_a,
   input  logic [COLOR_BITS-1:0]    req_green_a,
   input  logic [COLOR_BITS-1:0]    req_blue_a,
   input  logic [COLOR_BITS-1:0]    req_red_b,
   input  logic [COLOR_BITS-1:0]    req_green_b,
   input  logic [COLOR_BITS-1:0]    req_blue_b,
   input  logic [FRACTION_BITS:0]   req_tween,
   input  logic                     req_direction,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [COLOR_BITS-1:0]    rsp_red_out,
   output logic [COLOR_BITS-1:0]    rsp_green_out,
   output logic [COLOR_BITS-1:0]    rsp_blue_out
);

   localparam int CB    = COLOR_BITS;
   localparam int FB    = FRACTION_BITS;
   localparam int ONE_W = FB + 1;
   localparam int W     = CB + FB;
   localparam int DL    = (W + ctw_pkg::DIV_STEPS - 1) / ctw_pkg::DIV_STEPS;
   localparam int HW    = FB + 3;
   localparam int LREP  = (FB + CB - 1) / CB;

   localparam logic [ONE_W-1:0] ONE  = {1'b1, {FB{1'b0}}};
   localparam logic [CB-1:0]    CMAX = {CB{1'b1}};

   typedef struct packed {
      logic [CB-1:0] mx;
      logic [CB-1:0] md;
      logic [CB-1:0] mn;
      logic [2:0]    zone;
      logic          rise;
   } sort_type;

   typedef struct packed {
      logic [ONE_W-1:0]      t;
      logic                  dir;
      logic [1:0][2:0]       zone;
      logic [1:0]            rise;
      logic [1:0]            black;
      logic [1:0]            gray;
      logic [1:0][ONE_W-1:0] l;
   } side1_type;

   typedef struct packed {
      logic [ONE_W-1:0]      t;
      logic                  dir;
      logic [1:0]            zero_hue;
      logic [1:0][ONE_W-1:0] l;
      logic [1:0][ONE_W-1:0] s;
   } side2_type;

   // Sort one color into max/mid/min and its wheel zone; r>=g ties first.
   function automatic sort_type sort_rgb(input logic [CB-1:0] r, input logic [CB-1:0] g,
                                         input logic [CB-1:0] b);
      sort_type o;
      if (r >= g) begin
         if (b > r) begin
            o = '{mx: b, md: r, mn: g, zone: ctw_pkg::HUE_BLUE, rise: 1'b1};
         end else if (b > g) begin
            o = '{mx: r, md: b, mn: g, zone: ctw_pkg::HUE_MAGENTA, rise: 1'b0};
         end else begin
            o = '{mx: r, md: g, mn: b, zone: ctw_pkg::HUE_RED, rise: 1'b1};
         end
      end else begin
         if (b > g) begin
            o = '{mx: b, md: g, mn: r, zone: ctw_pkg::HUE_CYAN, rise: 1'b0};
         end else if (b > r) begin
            o = '{mx: g, md: b, mn: r, zone: ctw_pkg::HUE_GREEN, rise: 1'b1};
         end else begin
            o = '{mx: g, md: r, mn: b, zone: ctw_pkg::HUE_YELLOW, rise: 1'b0};
         end
      end
      return o;
   endfunction

   // Global advance: the pipe moves unless a result sits unaccepted.
   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // ---------------- P0: capture, clamp tween ----------------
   logic             v0_ff;
   logic [CB-1:0]    rgb0_ff [2][3];
   logic [ONE_W-1:0] t0_ff;
   logic             dir0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rgb0_ff[0][0] <= req_red_a;
         rgb0_ff[0][1] <= req_green_a;
         rgb0_ff[0][2] <= req_blue_a;
         rgb0_ff[1][0] <= req_red_b;
         rgb0_ff[1][1] <= req_green_b;
         rgb0_ff[1][2] <= req_blue_b;
         t0_ff         <= (req_tween > ONE) ? ONE : req_tween;
         dir0_ff       <= req_direction;
      end
   end

   // ---------------- P1: order components ----------------
   logic             v1_ff;
   sort_type         srt1_ff [2];
   logic [ONE_W-1:0] t1_ff;
   logic             dir1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 2; c++) begin
            srt1_ff[c] <= sort_rgb(rgb0_ff[c][0], rgb0_ff[c][1], rgb0_ff[c][2]);
         end
         t1_ff   <= t0_ff;
         dir1_ff <= dir0_ff;
      end
   end

   // ---------------- divider bank: min/max, middle ----------------
   logic [W-1:0] qs [2];
   logic [W-1:0] qf [2];

   for (genvar c = 0; c < 2; c++) begin : g_div1
      logic [CB-1:0] span;
      logic [CB-1:0] mid_off;
      assign span    = srt1_ff[c].mx - srt1_ff[c].mn;
      assign mid_off = srt1_ff[c].md - srt1_ff[c].mn;

      ctw_div #(.NUM_W(W), .DEN_W(CB)) u_div_s (
         .clock (clock),
         .en    (en),
         .num   ({srt1_ff[c].mn, {FB{1'b0}}}),
         .den   (srt1_ff[c].mx),
         .quo   (qs[c])
      );

      ctw_div #(.NUM_W(W), .DEN_W(CB)) u_div_f (
         .clock (clock),
         .en    (en),
         .num   ({mid_off, {FB{1'b0}}}),
         .den   (span),
         .quo   (qf[c])
      );
   end

   // Side data riding along with the divider bank.
   side1_type side1_in;
   side1_type side1_ff [DL];
   logic      vd1_ff   [DL];

   // max/CMAX: below all ones the fraction is the max repeated, truncated
   always_comb begin
      logic [LREP*CB-1:0] rep;
      side1_in.t   = t1_ff;
      side1_in.dir = dir1_ff;
      for (int c = 0; c < 2; c++) begin
         rep               = {LREP{srt1_ff[c].mx}};
         side1_in.zone[c]  = srt1_ff[c].zone;
         side1_in.rise[c]  = srt1_ff[c].rise;
         side1_in.black[c] = (srt1_ff[c].mx == '0);
         side1_in.gray[c]  = (srt1_ff[c].mx == srt1_ff[c].mn);
         side1_in.l[c]     = (srt1_ff[c].mx == CMAX) ? ONE
                                                     : {1'b0, rep[LREP*CB-1 -: FB]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DL; k++) begin
            vd1_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vd1_ff[0] <= v1_ff;
         for (int k = 1; k < DL; k++) begin
            vd1_ff[k] <= vd1_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff[0] <= side1_in;
         for (int k = 1; k < DL; k++) begin
            side1_ff[k] <= side1_ff[k-1];
         end
      end
   end

   // ---------------- P2: lightness, saturation, hue numerator ----------------
   logic             v2_ff;
   side1_type        sd1;
   logic [ONE_W-1:0] l2_ff  [2];
   logic [ONE_W-1:0] s2_ff  [2];
   logic [W-1:0]     hn2_ff [2];
   logic [1:0]       zh2_ff;
   logic [ONE_W-1:0] t2_ff;
   logic             dir2_ff;

   assign sd1 = side1_ff[DL-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= vd1_ff[DL-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 2; c++) begin
            l2_ff[c] <= sd1.l[c];
            // black: full saturation; gray: none
            if (sd1.black[c]) begin
               s2_ff[c] <= ONE;
            end else if (sd1.gray[c]) begin
               s2_ff[c] <= '0;
            end else begin
               s2_ff[c] <= ONE - qs[c][ONE_W-1:0];
            end
            hn2_ff[c] <= W'({sd1.zone[c], {FB{1'b0}}})
                       + W'(sd1.rise[c] ? qf[c][ONE_W-1:0] : ONE - qf[c][ONE_W-1:0]);
         end
         zh2_ff  <= sd1.black | sd1.gray;
         t2_ff   <= sd1.t;
         dir2_ff <= sd1.dir;
      end
   end

   // ---------------- hue stage: numerator / 6 ----------------
   // n/6 = (n/2)/3; the divide by three multiplies by ceil(2^(HN_W+1)/3),
   // exact for every half numerator below 2^HN_W.
   localparam int HN_W = FB + 2;
   localparam logic [HN_W-1:0] THIRD = HN_W'(((64'd1 << (HN_W + 1)) + 64'd2) / 64'd3);

   logic [ONE_W-1:0] qh_ff [2];

   for (genvar c = 0; c < 2; c++) begin : g_hue
      logic [2*HN_W-1:0] prod;
      assign prod = hn2_ff[c][HN_W:1] * THIRD;
      always_ff @(posedge clock) begin
         if (en) begin
            qh_ff[c] <= prod[2*HN_W-1 -: ONE_W];
         end
      end
   end

   side2_type side2_in;
   side2_type side2_ff;
   logic      vd2_ff;

   always_comb begin
      side2_in.t        = t2_ff;
      side2_in.dir      = dir2_ff;
      side2_in.zero_hue = zh2_ff;
      for (int c = 0; c < 2; c++) begin
         side2_in.l[c] = l2_ff[c];
         side2_in.s[c] = s2_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd2_ff <= 1'b0;
      end else if (en) begin
         vd2_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side2_ff <= side2_in;
      end
   end

   // ---------------- P3: hue wrap, blend distances ----------------
   side2_type        sd2;
   logic [FB-1:0]    hue3 [2];
   logic [ONE_W-1:0] hfar;
   logic [ONE_W-1:0] hnear;
   logic [ONE_W-1:0] s_a3;
   logic [ONE_W-1:0] s_b3;
   logic [ONE_W-1:0] l_a3;
   logic [ONE_W-1:0] l_b3;

   assign sd2 = side2_ff;

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         // a hue of a full turn wraps to zero
         if (sd2.zero_hue[c] || (qh_ff[c] >= ONE)) begin
            hue3[c] = '0;
         end else begin
            hue3[c] = qh_ff[c][FB-1:0];
         end
      end
      // forward travel measures first->second, backward second->first
      hfar  = {1'b0, sd2.dir ? hue3[0] : hue3[1]};
      hnear = {1'b0, sd2.dir ? hue3[1] : hue3[0]};
      s_a3  = sd2.s[0];
      s_b3  = sd2.s[1];
      l_a3  = sd2.l[0];
      l_b3  = sd2.l[1];
   end

   logic             v3_ff;
   logic [ONE_W-1:0] t3_ff;
   logic             dir3_ff;
   logic [FB-1:0]    h13_ff;
   logic [ONE_W-1:0] hm3_ff;
   logic [ONE_W-1:0] s13_ff;
   logic [ONE_W-1:0] sm3_ff;
   logic             sn3_ff;
   logic [ONE_W-1:0] l13_ff;
   logic [ONE_W-1:0] lm3_ff;
   logic             ln3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= vd2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t3_ff   <= sd2.t;
         dir3_ff <= sd2.dir;
         h13_ff  <= hue3[0];
         hm3_ff  <= (hfar >= hnear) ? hfar - hnear : ONE - (hnear - hfar);
         s13_ff  <= s_a3;
         sn3_ff  <= (s_b3 < s_a3);
         sm3_ff  <= (s_b3 < s_a3) ? s_a3 - s_b3 : s_b3 - s_a3;
         l13_ff  <= l_a3;
         ln3_ff  <= (l_b3 < l_a3);
         lm3_ff  <= (l_b3 < l_a3) ? l_a3 - l_b3 : l_b3 - l_a3;
      end
   end

   // ---------------- P4: tween products ----------------
   logic [2*ONE_W-1:0] hprod;
   logic [2*ONE_W-1:0] sprod;
   logic [2*ONE_W-1:0] lprod;

   assign hprod = t3_ff * hm3_ff;
   assign sprod = t3_ff * sm3_ff;
   assign lprod = t3_ff * lm3_ff;

   logic             v4_ff;
   logic             dir4_ff;
   logic [FB-1:0]    h14_ff;
   logic [ONE_W-1:0] hv4_ff;
   logic [ONE_W-1:0] s14_ff;
   logic [ONE_W-1:0] sv4_ff;
   logic             sn4_ff;
   logic [ONE_W-1:0] l14_ff;
   logic [ONE_W-1:0] lv4_ff;
   logic             ln4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dir4_ff <= dir3_ff;
         h14_ff  <= h13_ff;
         hv4_ff  <= hprod[FB +: ONE_W];
         s14_ff  <= s13_ff;
         sv4_ff  <= sprod[FB +: ONE_W];
         sn4_ff  <= sn3_ff;
         l14_ff  <= l13_ff;
         lv4_ff  <= lprod[FB +: ONE_W];
         ln4_ff  <= ln3_ff;
      end
   end

   // ---------------- P5: finish blend, wrap hue ----------------
   logic [FB+1:0] hsum;
   logic [FB+1:0] hdif;
   logic [FB+1:0] hres;

   always_comb begin
      hsum = {2'b00, h14_ff} + {1'b0, hv4_ff};
      if (hsum >= {1'b0, ONE}) begin
         hsum = hsum - {1'b0, ONE};
      end
      if ({1'b0, hv4_ff} > {2'b00, h14_ff}) begin
         hdif = {2'b00, h14_ff} + {1'b0, ONE} - {1'b0, hv4_ff};
      end else begin
         hdif = {2'b00, h14_ff} - {1'b0, hv4_ff};
      end
      hres = dir4_ff ? hdif : hsum;
   end

   logic             v5_ff;
   logic [FB-1:0]    h5_ff;
   logic [ONE_W-1:0] s5_ff;
   logic [ONE_W-1:0] l5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h5_ff <= hres[FB-1:0];
         s5_ff <= sn4_ff ? s14_ff - sv4_ff : s14_ff + sv4_ff;
         l5_ff <= ln4_ff ? l14_ff - lv4_ff : l14_ff + lv4_ff;
      end
   end

   // ---------------- P6: hue back to pure RGB ramp ----------------
   logic [HW-1:0]    h6x;
   logic [2:0]       sect6;
   logic [ONE_W-1:0] ramp6;
   logic [ONE_W-1:0] pure6 [3];

   always_comb begin
      h6x   = (HW'(h5_ff) << 2) + (HW'(h5_ff) << 1);
      sect6 = h6x[FB +: 3];
      ramp6 = {1'b0, h6x[FB-1:0]};
      case (sect6)
         ctw_pkg::HUE_RED: begin
            pure6[0] = ONE;         pure6[1] = ramp6;       pure6[2] = '0;
         end
         ctw_pkg::HUE_YELLOW: begin
            pure6[0] = ONE - ramp6; pure6[1] = ONE;         pure6[2] = '0;
         end
         ctw_pkg::HUE_GREEN: begin
            pure6[0] = '0;          pure6[1] = ONE;         pure6[2] = ramp6;
         end
         ctw_pkg::HUE_CYAN: begin
            pure6[0] = '0;          pure6[1] = ONE - ramp6; pure6[2] = ONE;
         end
         ctw_pkg::HUE_BLUE: begin
            pure6[0] = ramp6;       pure6[1] = '0;          pure6[2] = ONE;
         end
         default: begin
            pure6[0] = ONE;         pure6[1] = '0;          pure6[2] = ONE - ramp6;
         end
      endcase
   end

   logic             v6_ff;
   logic [ONE_W-1:0] c6_ff [3];
   logic [ONE_W-1:0] s6_ff;
   logic [ONE_W-1:0] l6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            c6_ff[i] <= pure6[i];
         end
         s6_ff <= s5_ff;
         l6_ff <= l5_ff;
      end
   end

   // ---------------- P7: apply saturation ----------------
   logic             v7_ff;
   logic [ONE_W-1:0] m7_ff [3];
   logic [ONE_W-1:0] l7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= v6_ff;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_sat
      logic [2*ONE_W-1:0] prod;
      assign prod = s6_ff * (ONE - c6_ff[i]);
      always_ff @(posedge clock) begin
         if (en) begin
            m7_ff[i] <= ONE - prod[FB +: ONE_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l7_ff <= l6_ff;
      end
   end

   // ---------------- P8: apply lightness ----------------
   logic             v8_ff;
   logic [ONE_W-1:0] w8_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (en) begin
         v8_ff <= v7_ff;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lit
      logic [2*ONE_W-1:0] prod;
      assign prod = m7_ff[i] * l7_ff;
      always_ff @(posedge clock) begin
         if (en) begin
            w8_ff[i] <= prod[FB +: ONE_W];
         end
      end
   end

   // ---------------- output register: scale to color range ----------------
   // v*CMAX = (v << CB) - v
   logic [CB-1:0] scaled [3];

   for (genvar i = 0; i < 3; i++) begin : g_scale
      logic [ONE_W+CB-1:0] ext;
      assign ext       = {w8_ff[i], {CB{1'b0}}} - (ONE_W+CB)'(w8_ff[i]);
      assign scaled[i] = ext[FB +: CB];
   end

   logic [CB-1:0] red_ff;
   logic [CB-1:0] green_ff;
   logic [CB-1:0] blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff   <= scaled[0];
         green_ff <= scaled[1];
         blue_ff  <= scaled[2];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;

   // ---------------- assertions ----------------
   a_last_stage_moves : assert property (@(posedge clock) disable iff (reset)
      en && v8_ff |=> rsp_valid_ff)
      else $error("item lost between last stage and output register");

   a_sector_legal : assert property (@(posedge clock) disable iff (reset)
      v5_ff |-> (sect6 != 3'd6) && (sect6 != 3'd7))
      else $error("hue sector out of wheel");

   a_blend_range : assert property (@(posedge clock) disable iff (reset)
      v5_ff |-> (s5_ff <= ONE) && (l5_ff <= ONE))
      else $error("blended saturation or lightness above one");

   a_hue_dist : assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> hm3_ff <= ONE)
      else $error("hue travel distance above a full turn");

endmodule

`default_nettype wire

/* tb/sv/color_tween_via_hue_wheel_core_tb.sv */
// Testbench for color_tween_via_hue_wheel_core: directed table, then random color pairs,
// with a stalling receiver; each result is checked against a typed-in value or a built-in HSV blend predictor.
// Depends on ctw_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none

module color_tween_via_hue_wheel_core_tb;

   localparam int CB = 8;
   localparam int FB = 16;
   localparam longint ONE = 64'd1 << FB;
   localparam longint CMAX = (64'd1 << CB) - 1;
   localparam int N_RANDOM = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_STALL = 60;

   typedef struct packed {
      logic [CB-1:0] r, g, b;
   } rgb_type;

   typedef struct {
      rgb_type a, b;
      logic [FB:0] tween;
      logic   dir;
      logic   has_known; // expected result typed in by hand
      rgb_type known;
   } tween_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [CB-1:0] req_red_a = '0, req_green_a = '0, req_blue_a = '0;
   logic [CB-1:0] req_red_b = '0, req_green_b = '0, req_blue_b = '0;
   logic [FB:0] req_tween = '0;
   logic req_direction = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [CB-1:0] rsp_red_out, rsp_green_out, rsp_blue_out;

   rgb_type blend_queue[$];   // expected blended colors, oldest first
   int     error_count = 0;
   int     idle_cycles = 0;
   bit     stimulus_done = 1'b0;
   bit     quiet_phase = 1'b0;   // last part of run: no idling on either side
   bit     hold_off = 1'b0;      // long receiver stall request

   color_tween_via_hue_wheel_core #(.COLOR_BITS(CB), .FRACTION_BITS(FB)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_red_a(req_red_a), .req_green_a(req_green_a), .req_blue_a(req_blue_a),
      .req_red_b(req_red_b), .req_green_b(req_green_b), .req_blue_b(req_blue_b),
      .req_tween(req_tween), .req_direction(req_direction),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_red_out(rsp_red_out), .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // RGB -> hue, saturation, lightness as Q1.16 fractions.
   task automatic split_hsl(input rgb_type c, output longint h, output longint s,
                            output longint l);
      longint r, g, b, mx, md, mn, zone, f, x;
      bit rising;
      r = longint'(c.r); g = longint'(c.g); b = longint'(c.b);
      if (r >= g) begin
         if (b > r) begin
            zone = longint'(ctw_pkg::HUE_BLUE); mx = b; md = r; mn = g; rising = 1;
         end else if (b > g) begin
            zone = longint'(ctw_pkg::HUE_MAGENTA); mx = r; md = b; mn = g; rising = 0;
         end else begin
            zone = longint'(ctw_pkg::HUE_RED); mx = r; md = g; mn = b; rising = 1;
         end
      end else begin
         if (b > g) begin
            zone = longint'(ctw_pkg::HUE_CYAN); mx = b; md = g; mn = r; rising = 0;
         end else if (b > r) begin
            zone = longint'(ctw_pkg::HUE_GREEN); mx = g; md = b; mn = r; rising = 1;
         end else begin
            zone = longint'(ctw_pkg::HUE_YELLOW); mx = g; md = r; mn = b; rising = 0;
         end
      end
      l = mx * ONE / CMAX;
      h = 0;
      if (mx == 0) begin
         s = ONE;   // black
      end else if (mx == mn) begin
         s = 0;     // gray
      end else begin
         s = ONE - (mn * ONE / mx);
         f = (md - mn) * ONE / (mx - mn);
         x = rising ? f : ONE - f;
         h = (zone * ONE + x) / 6;
         if (h >= ONE) h = 0;
      end
   endtask

   function automatic longint mix_linear(longint v1, longint v2, longint t);
      if (v2 >= v1) return v1 + ((t * (v2 - v1)) >> FB);
      return v1 - ((t * (v1 - v2)) >> FB);
   endfunction

   function automatic logic [CB-1:0] shade_channel(longint c, longint s, longint l);
      longint v;
      v = ONE - ((s * (ONE - c)) >> FB);
      v = (v * l) >> FB;
      return CB'((v * CMAX) >> FB);
   endfunction

   task automatic predict_tween(input tween_row_type row, output rgb_type res);
      longint h1, s1, l1, h2, s2, l2, h, s, l, t, d, v, p, sector, rc, gc, bc;
      t = longint'(row.tween);
      if (t > ONE) t = ONE;   // tween above 1.0 clamps
      split_hsl(row.a, h1, s1, l1);
      split_hsl(row.b, h2, s2, l2);
      if (!row.dir) begin
         if (h2 >= h1) h = h1 + ((t * (h2 - h1)) >> FB);
         else begin
            d = ONE - (h1 - h2);
            h = h1 + ((t * d) >> FB);
         end
      end else begin
         if (h1 >= h2) h = h1 - ((t * (h1 - h2)) >> FB);
         else begin
            d = ONE - (h2 - h1);
            v = (t * d) >> FB;
            h = (v > h1) ? h1 + ONE - v : h1 - v;
         end
      end
      if (h >= ONE) h -= ONE;   // wrap at full turn
      s = mix_linear(s1, s2, t);
      l = mix_linear(l1, l2, t);
      v = h * 6;
      sector = v >> FB;
      p = v & (ONE - 1);
      case (sector)
         ctw_pkg::HUE_RED: begin
            rc = ONE; gc = p; bc = 0;
         end
         ctw_pkg::HUE_YELLOW: begin
            rc = ONE - p; gc = ONE; bc = 0;
         end
         ctw_pkg::HUE_GREEN: begin
            rc = 0; gc = ONE; bc = p;
         end
         ctw_pkg::HUE_CYAN: begin
            rc = 0; gc = ONE - p; bc = ONE;
         end
         ctw_pkg::HUE_BLUE: begin
            rc = p; gc = 0; bc = ONE;
         end
         default: begin
            rc = ONE; gc = 0; bc = ONE - p;
         end
      endcase
      res.r = shade_channel(rc, s, l);
      res.g = shade_channel(gc, s, l);
      res.b = shade_channel(bc, s, l);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic rgb_type pack_rgb(int r, int g, int b);
      rgb_type c;
      c.r = CB'(r); c.g = CB'(g); c.b = CB'(b);
      return c;
   endfunction

   function automatic tween_row_type make_row(rgb_type a, rgb_type b, int t, bit dir,
                                              bit known_ok = 0, rgb_type known = '0);
      tween_row_type row;
      row.a = a; row.b = b; row.tween = (FB+1)'(t); row.dir = dir;
      row.has_known = known_ok; row.known = known;
      return row;
   endfunction

   // Random color: mostly full range, sometimes ties, grays and extremes.
   function automatic rgb_type random_color();
      rgb_type c;
      c = pack_rgb($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      case ($urandom_range(0, 9))
         0: c.g = c.r;
         1: c.b = c.r;
         2: begin
            c.g = c.r; c.b = c.r;
         end
         3: c = pack_rgb($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                         $urandom_range(0, 1) * 255);
         default: ;
      endcase
      return c;
   endfunction

   // Drive one item and hold it until accepted.
   task automatic send_item(input tween_row_type row);
      rgb_type want;
      int gap;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red_a <= row.a.r; req_green_a <= row.a.g; req_blue_a <= row.a.b;
      req_red_b <= row.b.r; req_green_b <= row.b.g; req_blue_b <= row.b.b;
      req_tween <= row.tween;
      req_direction <= row.dir;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_tween(row, want);
      if (row.has_known && want != row.known)
         report_mismatch("directed table entry", int'(want), int'(row.known));
      blend_queue.push_back(row.has_known ? row.known : want);
   endtask

   // Stimulus
   initial begin
      tween_row_type table_rows[$];
      tween_row_type row;
      rgb_type white, black, red;
      white = pack_rgb(255, 255, 255);
      black = pack_rgb(0, 0, 0);
      red = pack_rgb(255, 0, 0);
      // tween 0 returns first color, tween 1.0 and above returns the second
      table_rows.push_back(make_row(black, white, 0, 0, 1, black));
      table_rows.push_back(make_row(black, white, 65536, 0, 1, white));
      table_rows.push_back(make_row(red, black, 0, 1, 1, red));
      table_rows.push_back(make_row(red, red, 131071, 0, 1, red));
      table_rows.push_back(make_row(white, red, 98304, 1));
      // every zone, ties and gray, both directions, hue wraparound
      table_rows.push_back(make_row(pack_rgb(255, 128, 0), pack_rgb(0, 255, 64), 32768, 0));
      table_rows.push_back(make_row(pack_rgb(128, 255, 0), pack_rgb(0, 128, 255), 32768, 1));
      table_rows.push_back(make_row(pack_rgb(0, 255, 128), pack_rgb(128, 0, 255), 16384, 0));
      table_rows.push_back(make_row(pack_rgb(255, 0, 128), pack_rgb(255, 0, 1), 49152, 0));
      table_rows.push_back(make_row(pack_rgb(255, 0, 1), pack_rgb(255, 1, 0), 32768, 0));
      table_rows.push_back(make_row(pack_rgb(255, 0, 1), pack_rgb(255, 1, 0), 32768, 1));
      table_rows.push_back(make_row(pack_rgb(255, 255, 0), pack_rgb(0, 255, 255), 1, 1));
      table_rows.push_back(make_row(pack_rgb(255, 0, 255), pack_rgb(0, 0, 255), 65535, 0));
      table_rows.push_back(make_row(pack_rgb(100, 100, 100), pack_rgb(10, 200, 30), 40000, 1));
      table_rows.push_back(make_row(pack_rgb(1, 0, 0), pack_rgb(0, 0, 1), 70000, 0));
      table_rows.push_back(make_row(pack_rgb(200, 200, 10), pack_rgb(10, 200, 200), 20000, 0));
      table_rows.push_back(make_row(pack_rgb(200, 10, 200), pack_rgb(254, 255, 253), 65536, 1));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (table_rows[i]) send_item(table_rows[i]);
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM / 4) hold_off <= 1'b1;
         if (n == N_RANDOM * 3 / 4) quiet_phase = 1'b1;
         row.a = random_color();
         row.b = random_color();
         case ($urandom_range(0, 5))
            0: row.tween = $urandom_range(0, 1) ? 17'd0 : 17'd65536;
            1: row.tween = 17'($urandom_range(65537, 131071));
            default: row.tween = 17'($urandom_range(0, 65536));
         endcase
         row.dir = 1'($urandom_range(0, 1));
         row.has_known = 1'b0;
         send_item(row);
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // Receiver: random stall bursts, one long hold-off, none at the end.
   initial begin
      int gap;
      bit held;
      held = 0;
      @(negedge reset);
      forever begin
         if (hold_off && !held) begin
            held = 1;
            rsp_ready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Result checker
   always @(posedge clock) begin
      rgb_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (blend_queue.size() == 0) begin
            $display("%0t: result with nothing expected", $realtime);
            error_count++;
         end else begin
            want = blend_queue.pop_front();
            if (rsp_red_out !== want.r)
               report_mismatch("red_out", int'(rsp_red_out), int'(want.r));
            if (rsp_green_out !== want.g)
               report_mismatch("green_out", int'(rsp_green_out), int'(want.g));
            if (rsp_blue_out !== want.b)
               report_mismatch("blue_out", int'(rsp_blue_out), int'(want.b));
         end
      end
   end

   // Watchdog on cycles with no accepted item
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // End of run
   initial begin
      wait (stimulus_done);
      while (blend_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
